>>> rtl/core/acf_pkg.sv
// ============================================================================
// acf_pkg: shared widths and types for the arc-center-from-bulge pipeline
// Fixed-point formats, CORDIC and divider sizes, and the records that travel
// between the pipeline sections.
// ============================================================================
package acf_pkg;

  // Field formats
  localparam int COORD_W  = 32;              // signed coordinate, FRAC_W fraction bits
  localparam int FRAC_W   = 16;
  localparam int BULGE_W  = 24;              // signed bulge, FRAC_W fraction bits
  localparam int RAD_W    = COORD_W - 1;     // unsigned radius

  // Chord and bulge terms
  localparam int DIFF_W   = COORD_W + 1;     // end minus start
  localparam int B2_W     = 2 * BULGE_W;     // bulge squared
  localparam int HALF_W   = B2_W / 2;        // split point of the wide multiplies

  // CORDIC vectoring
  localparam int GUARD_W  = 8;
  localparam int STEPS    = 24;
  localparam int CX_W     = DIFF_W + GUARD_W + 4;  // signed working width
  localparam int XU_W     = CX_W - 1;              // final x, never negative

  // Gain removal: 1/K as Q0.32, split in two 16-bit halves
  localparam int               GAIN_SPLIT = 16;
  localparam logic [15:0]      GAIN_HI    = 16'h9B74;
  localparam logic [15:0]      GAIN_LO    = 16'hEDA8;
  localparam int               CHORD_SHIFT = 32 + GUARD_W;
  localparam int               CHORD_W    = 36;

  // Divider: quotient of num by (m << DEN_SHIFT), rounded
  localparam int DEN_SHIFT = FRAC_W + 2;
  localparam int NUM_W     = 85;
  localparam int DVD_W     = NUM_W - DEN_SHIFT;
  localparam int QW        = 34;             // quotient bits, all ones on overflow
  localparam int HI_W      = DVD_W - QW;

  // Divider lanes
  localparam int LANES    = 3;
  localparam int LANE_TY  = 0;               // |dy| * |1 - b^2| / 4b
  localparam int LANE_TX  = 1;               // |dx| * |1 - b^2| / 4b
  localparam int LANE_RAD = 2;               // chord * (1 + b^2) / 4b

  // Fields that ride to the final combine
  typedef struct packed {
    logic                        zero;
    logic                        kneg;
    logic                        sdx;
    logic                        sdy;
    logic signed [COORD_W-1:0]   mx;
    logic signed [COORD_W-1:0]   my;
  } tail_t;

  // Output of the front section
  typedef struct packed {
    logic [DIFF_W-1:0]  adx;
    logic [DIFF_W-1:0]  ady;
    logic [B2_W-1:0]    n2m;
    logic [B2_W-1:0]    sumb;
    logic [BULGE_W-1:0] m;
    tail_t              tail;
  } front_t;

endpackage

>>> rtl/core/acf_front.sv
// ============================================================================
// acf_front: input section of the arc-center pipeline
// Three stages: differences and midpoint, magnitudes and bulge square,
// then the 1 - b^2 and 1 + b^2 terms and the sign of the center offset.
// ============================================================================
module acf_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [acf_pkg::COORD_W-1:0] start_x,
  input  logic signed [acf_pkg::COORD_W-1:0] start_y,
  input  logic signed [acf_pkg::COORD_W-1:0] end_x,
  input  logic signed [acf_pkg::COORD_W-1:0] end_y,
  input  logic signed [acf_pkg::BULGE_W-1:0] bulge,
  output logic                               out_valid,
  output acf_pkg::front_t                    out_side
);

  localparam int CW = acf_pkg::COORD_W;
  localparam int DW = acf_pkg::DIFF_W;
  localparam int BW = acf_pkg::BULGE_W;
  localparam int QW2 = acf_pkg::B2_W;
  localparam logic [QW2:0] ONE_Q = (QW2 + 1)'(1) << (2 * acf_pkg::FRAC_W);

  // stage 1
  logic                 v1;
  logic signed [DW-1:0] dx1, dy1;
  logic signed [CW-1:0] mx1, my1;
  logic [BW-1:0]        m1;
  logic                 bneg1, zero1;

  // stage 2
  logic                 v2;
  logic [DW-1:0]        adx2, ady2;
  logic [QW2-1:0]       b2_2;
  logic [BW-1:0]        m2;
  logic                 bneg2, zero2, sdx2, sdy2;
  logic signed [CW-1:0] mx2, my2;

  logic signed [DW-1:0] sx_e, sy_e, ex_e, ey_e, sum_x, sum_y;
  logic [BW-1:0]        braw, babs;
  logic [QW2:0]         b2e;
  logic                 n2neg;
  logic [QW2:0]         n2abs, sumbe;

  // sign-extend and form differences and sums
  assign sx_e  = {start_x[CW-1], start_x};
  assign sy_e  = {start_y[CW-1], start_y};
  assign ex_e  = {end_x[CW-1], end_x};
  assign ey_e  = {end_y[CW-1], end_y};
  assign sum_x = sx_e + ex_e;
  assign sum_y = sy_e + ey_e;
  assign braw  = bulge;
  assign babs  = braw[BW-1] ? (~braw + BW'(1)) : braw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // stage 1: differences, floored midpoint, bulge magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= ex_e - sx_e;
      dy1   <= ey_e - sy_e;
      mx1   <= sum_x[DW-1:1];
      my1   <= sum_y[DW-1:1];
      m1    <= babs;
      bneg1 <= braw[BW-1];
      zero1 <= (braw == '0);
    end
  end

  // stage 2: magnitudes of the chord components, bulge squared
  always_ff @(posedge clk) begin
    if (en) begin
      adx2  <= dx1[DW-1] ? (~dx1 + DW'(1)) : dx1;
      ady2  <= dy1[DW-1] ? (~dy1 + DW'(1)) : dy1;
      sdx2  <= dx1[DW-1];
      sdy2  <= dy1[DW-1];
      b2_2  <= QW2'(m1) * QW2'(m1);
      m2    <= m1;
      bneg2 <= bneg1;
      zero2 <= zero1;
      mx2   <= mx1;
      my2   <= my1;
    end
  end

  // stage 3: |1 - b^2|, 1 + b^2, sign of the offset factor
  assign b2e   = {1'b0, b2_2};
  assign n2neg = (b2e > ONE_Q);
  assign n2abs = n2neg ? (b2e - ONE_Q) : (ONE_Q - b2e);
  assign sumbe = b2e + ONE_Q;

  always_ff @(posedge clk) begin
    if (en) begin
      out_side.adx       <= adx2;
      out_side.ady       <= ady2;
      out_side.n2m       <= n2abs[QW2-1:0];
      out_side.sumb      <= sumbe[QW2-1:0];
      out_side.m         <= m2;
      out_side.tail.zero <= zero2;
      out_side.tail.kneg <= n2neg ^ bneg2;
      out_side.tail.sdx  <= sdx2;
      out_side.tail.sdy  <= sdy2;
      out_side.tail.mx   <= mx2;
      out_side.tail.my   <= my2;
    end
  end

endmodule

>>> rtl/core/acf_cordic.sv
// ============================================================================
// acf_cordic: pipelined CORDIC in vectoring mode
// One rotation per stage drives y toward zero; x ends as the scaled chord
// length. The front record travels alongside, one copy per stage.
// ============================================================================
module acf_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  acf_pkg::front_t                 in_side,
  output logic                            out_valid,
  output logic [acf_pkg::XU_W-1:0]        out_x,
  output acf_pkg::front_t                 out_side
);

  localparam int N  = acf_pkg::STEPS;
  localparam int XW = acf_pkg::CX_W;
  localparam int GW = acf_pkg::GUARD_W;
  localparam int DW = acf_pkg::DIFF_W;

  logic                 v  [0:N-1];
  logic signed [XW-1:0] xr [0:N-1];
  logic signed [XW-1:0] yr [0:N-2];
  acf_pkg::front_t      sr [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_it
    logic signed [XW-1:0] xa, ya, xs, ys;
    logic                 va;
    acf_pkg::front_t      sa;

    // pick this stage's source
    if (k == 0) begin : g_first
      assign xa = XW'({in_side.adx, GW'(0)});
      assign ya = XW'({in_side.ady, GW'(0)});
      assign va = in_valid;
      assign sa = in_side;
    end else begin : g_next
      assign xa = xr[k-1];
      assign ya = yr[k-1];
      assign va = v[k-1];
      assign sa = sr[k-1];
    end

    assign xs = xa >>> k;
    assign ys = ya >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= va;
      end
    end

    // rotate toward the x axis
    always_ff @(posedge clk) begin
      if (en) begin
        sr[k] <= sa;
        xr[k] <= ya[XW-1] ? (xa - ys) : (xa + ys);
      end
    end

    if (k < N - 1) begin : g_y
      always_ff @(posedge clk) begin
        if (en) begin
          yr[k] <= ya[XW-1] ? (ya + xs) : (ya - xs);
        end
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_x     = xr[N-1][acf_pkg::XU_W-1:0];
  assign out_side  = sr[N-1];

endmodule

>>> rtl/core/acf_mul.sv
// ============================================================================
// acf_mul: multiply section of the arc-center pipeline
// Removes the CORDIC gain to get the chord, and forms the three dividends
// from split partial products over four stages.
// ============================================================================
module acf_mul (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [acf_pkg::XU_W-1:0]                      in_x,
  input  acf_pkg::front_t                               in_side,
  output logic                                          out_valid,
  output logic [acf_pkg::LANES-1:0][acf_pkg::NUM_W-1:0] out_num,
  output logic [acf_pkg::BULGE_W-1:0]                   out_m,
  output acf_pkg::tail_t                                out_tail
);

  localparam int HW  = acf_pkg::HALF_W;
  localparam int NW  = acf_pkg::NUM_W;
  localparam int BW  = acf_pkg::BULGE_W;
  localparam int GPW = acf_pkg::XU_W + acf_pkg::GAIN_SPLIT;
  localparam int SW  = GPW + acf_pkg::GAIN_SPLIT + 1;
  localparam int TW  = acf_pkg::DIFF_W + HW;
  localparam int RW  = acf_pkg::CHORD_W + HW;
  localparam int RS  = acf_pkg::DEN_SHIFT - 1;
  localparam logic [SW-1:0] CHORD_RND = SW'(1) << (acf_pkg::CHORD_SHIFT - 1);

  logic va, vb, vc;

  // stage A
  logic [GPW-1:0]            g_hi, g_lo;
  logic [TW-1:0]             pty_lo, pty_hi, ptx_lo, ptx_hi;
  logic [acf_pkg::B2_W-1:0]  sumb_a, sumb_b;
  logic [BW-1:0]             m_a, m_b, m_c;
  acf_pkg::tail_t            tail_a, tail_b, tail_c;

  // stage B
  logic [acf_pkg::CHORD_W-1:0] chord_b;
  logic [NW-1:0]               nty_b, ntx_b, nty_c, ntx_c;
  logic [SW-1:0]               gsum;

  // stage C
  logic [RW-1:0]               r_lo, r_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      out_valid <= vc;
    end
  end

  // stage A: gain and offset partial products
  always_ff @(posedge clk) begin
    if (en) begin
      g_hi   <= GPW'(in_x) * GPW'(acf_pkg::GAIN_HI);
      g_lo   <= GPW'(in_x) * GPW'(acf_pkg::GAIN_LO);
      pty_lo <= TW'(in_side.ady) * TW'(in_side.n2m[HW-1:0]);
      pty_hi <= TW'(in_side.ady) * TW'(in_side.n2m[2*HW-1:HW]);
      ptx_lo <= TW'(in_side.adx) * TW'(in_side.n2m[HW-1:0]);
      ptx_hi <= TW'(in_side.adx) * TW'(in_side.n2m[2*HW-1:HW]);
      sumb_a <= in_side.sumb;
      m_a    <= in_side.m;
      tail_a <= in_side.tail;
    end
  end

  // stage B: rounded chord, offset dividends with half divisor added
  assign gsum = (SW'(g_hi) << acf_pkg::GAIN_SPLIT) + SW'(g_lo) + CHORD_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      chord_b <= gsum[acf_pkg::CHORD_SHIFT +: acf_pkg::CHORD_W];
      nty_b   <= (NW'(pty_hi) << HW) + NW'(pty_lo) + (NW'(m_a) << RS);
      ntx_b   <= (NW'(ptx_hi) << HW) + NW'(ptx_lo) + (NW'(m_a) << RS);
      sumb_b  <= sumb_a;
      m_b     <= m_a;
      tail_b  <= tail_a;
    end
  end

  // stage C: radius partial products
  always_ff @(posedge clk) begin
    if (en) begin
      r_lo   <= RW'(chord_b) * RW'(sumb_b[HW-1:0]);
      r_hi   <= RW'(chord_b) * RW'(sumb_b[2*HW-1:HW]);
      nty_c  <= nty_b;
      ntx_c  <= ntx_b;
      m_c    <= m_b;
      tail_c <= tail_b;
    end
  end

  // stage D: radius dividend
  always_ff @(posedge clk) begin
    if (en) begin
      out_num[acf_pkg::LANE_TY]  <= nty_c;
      out_num[acf_pkg::LANE_TX]  <= ntx_c;
      out_num[acf_pkg::LANE_RAD] <= (NW'(r_hi) << HW) + NW'(r_lo) + (NW'(m_c) << RS);
      out_m    <= m_c;
      out_tail <= tail_c;
    end
  end

endmodule

>>> rtl/core/acf_div.sv
// ============================================================================
// acf_div: pipelined restoring divider, three lanes in lockstep
// Divides each dividend by (m << DEN_SHIFT), one quotient bit per stage.
// A quotient that does not fit in QW bits comes out as all ones.
// ============================================================================
module acf_div (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  logic [acf_pkg::LANES-1:0][acf_pkg::NUM_W-1:0] in_num,
  input  logic [acf_pkg::BULGE_W-1:0]                   in_m,
  input  acf_pkg::tail_t                                in_tail,
  output logic                                          out_valid,
  output logic [acf_pkg::LANES-1:0][acf_pkg::QW-1:0]    out_q,
  output acf_pkg::tail_t                                out_tail
);

  localparam int L  = acf_pkg::LANES;
  localparam int Q  = acf_pkg::QW;
  localparam int BW = acf_pkg::BULGE_W;
  localparam int HW = acf_pkg::HI_W;
  localparam int DV = acf_pkg::DVD_W;

  logic                        v    [0:Q];
  logic [L-1:0][BW-1:0]        rem  [0:Q-1];
  logic [L-1:0][Q-1:0]         sh   [0:Q];
  logic [L-1:0]                ovf  [0:Q];
  logic [BW-1:0]               md   [0:Q-1];
  acf_pkg::tail_t              tl   [0:Q];

  logic [L-1:0][BW-1:0]        rem0;
  logic [L-1:0][Q-1:0]         sh0;
  logic [L-1:0]                ovf0;

  // split the scaled dividend: high part checks overflow and seeds the remainder
  always_comb begin
    logic [DV-1:0] d;
    for (int l = 0; l < L; l++) begin
      d       = in_num[l][acf_pkg::NUM_W-1:acf_pkg::DEN_SHIFT];
      ovf0[l] = (d[DV-1:Q] >= HW'(in_m));
      rem0[l] = d[Q+BW-1:Q];
      sh0[l]  = d[Q-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem0;
      sh[0]  <= sh0;
      ovf[0] <= ovf0;
      md[0]  <= in_m;
      tl[0]  <= in_tail;
    end
  end

  for (genvar k = 1; k <= Q; k++) begin : g_step
    logic [L-1:0][BW-1:0] rem_n;
    logic [L-1:0][Q-1:0]  sh_n;

    // bring in one dividend bit, subtract where it fits
    always_comb begin
      logic [BW:0] t, diff;
      logic        ge;
      for (int l = 0; l < L; l++) begin
        t        = {rem[k-1][l], sh[k-1][l][Q-1]};
        diff     = t - {1'b0, md[k-1]};
        ge       = (t >= {1'b0, md[k-1]});
        rem_n[l] = ge ? diff[BW-1:0] : t[BW-1:0];
        sh_n[l]  = {sh[k-1][l][Q-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sh[k]  <= sh_n;
        ovf[k] <= ovf[k-1];
        tl[k]  <= tl[k-1];
      end
    end

    if (k < Q) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= rem_n;
          md[k]  <= md[k-1];
        end
      end
    end
  end

  // saturate overflowed lanes
  always_comb begin
    for (int l = 0; l < L; l++) begin
      out_q[l] = ovf[Q][l] ? '1 : sh[Q][l];
    end
  end

  assign out_valid = v[Q];
  assign out_tail  = tl[Q];

endmodule

>>> rtl/core/arc_center_from_bulge.sv
// ============================================================================
// arc_center_from_bulge: arc center and radius from end points and bulge
// Pipelined front, CORDIC chord, multiply section, divider and output stage.
// ============================================================================
// Takes one arc word (start, end, bulge) per cycle while in_stall is low and
// returns its center, radius and a degenerate flag in order. The chord comes
// from the 24-stage CORDIC, and the offsets and the radius from the 35-stage
// divider. A registered output with a one-word skid stage keeps accepting
// while a result waits; in_stall rises only once the skid stage is holding
// a word. Zero bulge returns the chord midpoint, the largest radius and
// degenerate set.
module arc_center_from_bulge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [acf_pkg::COORD_W-1:0]  start_x,
  input  logic signed [acf_pkg::COORD_W-1:0]  start_y,
  input  logic signed [acf_pkg::COORD_W-1:0]  end_x,
  input  logic signed [acf_pkg::COORD_W-1:0]  end_y,
  input  logic signed [acf_pkg::BULGE_W-1:0]  bulge,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [acf_pkg::COORD_W-1:0]  center_x,
  output logic signed [acf_pkg::COORD_W-1:0]  center_y,
  output logic [acf_pkg::RAD_W-1:0]           arc_radius,
  output logic                                degenerate
);

  localparam int CW = acf_pkg::COORD_W;
  localparam int RW = acf_pkg::RAD_W;
  localparam int Q  = acf_pkg::QW;
  localparam int EW = Q + 2;
  localparam logic [RW-1:0] RAD_MAX = '1;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [RW-1:0]        rad;
    logic                 deg;
  } res_t;

  logic                                          en;
  logic                                          f_v, c_v, m_v, d_v;
  acf_pkg::front_t                               f_side, c_side;
  logic [acf_pkg::XU_W-1:0]                      c_x;
  logic [acf_pkg::LANES-1:0][acf_pkg::NUM_W-1:0] m_num;
  logic [acf_pkg::BULGE_W-1:0]                   m_m;
  acf_pkg::tail_t                                m_tail, d_tail;
  logic [acf_pkg::LANES-1:0][Q-1:0]              d_q;

  res_t  res, out_w, skid_w;
  logic  skid_v, take;

  // whole pipeline moves unless the skid stage is holding a word
  assign en       = !skid_v;
  assign in_stall = skid_v;

  acf_front u_front (
    .clk, .rst, .en,
    .in_valid,
    .start_x, .start_y, .end_x, .end_y, .bulge,
    .out_valid (f_v),
    .out_side  (f_side)
  );

  acf_cordic u_cordic (
    .clk, .rst, .en,
    .in_valid  (f_v),
    .in_side   (f_side),
    .out_valid (c_v),
    .out_x     (c_x),
    .out_side  (c_side)
  );

  acf_mul u_mul (
    .clk, .rst, .en,
    .in_valid  (c_v),
    .in_x      (c_x),
    .in_side   (c_side),
    .out_valid (m_v),
    .out_num   (m_num),
    .out_m     (m_m),
    .out_tail  (m_tail)
  );

  acf_div u_div (
    .clk, .rst, .en,
    .in_valid  (m_v),
    .in_num    (m_num),
    .in_m      (m_m),
    .in_tail   (m_tail),
    .out_valid (d_v),
    .out_q     (d_q),
    .out_tail  (d_tail)
  );

  // clamp a wide signed value to the coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic [EW-1:0] v);
    logic [CW-1:0] r;
    if (v[EW-1:CW-1] == '0 || v[EW-1:CW-1] == '1) begin
      r = v[CW-1:0];
    end else if (v[EW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  // apply offset signs, add to the midpoint, saturate
  always_comb begin
    logic [EW-1:0] ty, tx, dyk, dxk, mxe, mye;
    ty  = EW'(d_q[acf_pkg::LANE_TY]);
    tx  = EW'(d_q[acf_pkg::LANE_TX]);
    dyk = (d_tail.sdy ^ d_tail.kneg) ? (~ty + EW'(1)) : ty;
    dxk = (d_tail.sdx ^ d_tail.kneg) ? (~tx + EW'(1)) : tx;
    mxe = {{(EW-CW){d_tail.mx[CW-1]}}, d_tail.mx};
    mye = {{(EW-CW){d_tail.my[CW-1]}}, d_tail.my};
    if (d_tail.zero) begin
      res.cx  = d_tail.mx;
      res.cy  = d_tail.my;
      res.rad = RAD_MAX;
      res.deg = 1'b1;
    end else begin
      res.cx  = sat_coord(mxe - dyk);
      res.cy  = sat_coord(mye + dxk);
      res.rad = (d_q[acf_pkg::LANE_RAD][Q-1:RW] != '0) ? RAD_MAX
                                                       : d_q[acf_pkg::LANE_RAD][RW-1:0];
      res.deg = 1'b0;
    end
  end

  // output register with one skid word
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        skid_v <= 1'b0;
      end
    end else if (d_v) begin
      if (out_valid && !take) begin
        skid_v <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        out_w <= skid_w;
      end
    end else if (d_v) begin
      if (out_valid && !take) begin
        skid_w <= res;
      end else begin
        out_w <= res;
      end
    end
  end

  assign center_x   = out_w.cx;
  assign center_y   = out_w.cy;
  assign arc_radius = out_w.rad;
  assign degenerate = out_w.deg;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid word held with empty output register");

  a_empty_no_skid: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> !skid_v)
    else $error("skid filled while output register was empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_v && out_stall) |=> skid_v && in_stall)
    else $error("skid word dropped while output stalled");

  a_deg_radius: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (arc_radius == RAD_MAX))
    else $error("degenerate word without saturated radius");
`endif

endmodule
